// ===== rtl/ssfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfr_pkg
// shared types and constants of the sync/sum frame receiver
// ----------------------------------------------------------------------------
package ssfr_pkg;

  localparam int POS_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

  localparam logic [BYTE_W-1:0] ID_SLOT0 = 8'd1;
  localparam logic [BYTE_W-1:0] ID_SLOT1 = 8'd3;
  localparam logic [BYTE_W-1:0] ID_SLOT2 = 8'd4;
  localparam logic [BYTE_W-1:0] ID_SLOT3 = 8'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BAD_ID   = 2'd2
  } ssfr_status_t;

  // frame end event from front to back
  typedef struct packed {
    ssfr_status_t status;
    logic [1:0]   slot;
  } ssfr_evt_t;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_READ = 4'b0010,
    BK_LOAD = 4'b0100,
    BK_HOLD = 4'b1000
  } ssfr_bk_state_t;

endpackage

// ===== rtl/ssfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ssfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 41,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ssfr_evq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfr_evq
// two entry queue of frame end events between front and back
// ----------------------------------------------------------------------------
module ssfr_evq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssfr_pkg::ssfr_evt_t push_data,
  input  logic               pop,
  output ssfr_pkg::ssfr_evt_t pop_data,
  output logic               empty,
  output logic               full,
  output logic [1:0]         count
);

  ssfr_pkg::ssfr_evt_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);
  assign count    = count_r;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ssfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfr_front
// byte intake: sync hunt, position count, running sum, store write, frame end
// ----------------------------------------------------------------------------
module ssfr_front #(
  parameter int FRAME_TOP = 40,
  parameter int AW        = $clog2(FRAME_TOP + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ssfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      line_error,
  input  logic                      q_full,
  input  logic                      dump_done,
  output logic                      ev_push,
  output ssfr_pkg::ssfr_evt_t       ev_data,
  output logic                      dump_hold,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [ssfr_pkg::BYTE_W-1:0] wr_data
);

  localparam logic [ssfr_pkg::POS_W-1:0] TOP    = ssfr_pkg::POS_W'(FRAME_TOP);
  localparam logic [ssfr_pkg::POS_W-1:0] TOP_M1 = ssfr_pkg::POS_W'(FRAME_TOP - 1);
  localparam logic [ssfr_pkg::POS_W-1:0] TOP_M2 = ssfr_pkg::POS_W'(FRAME_TOP - 2);

  logic [ssfr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [ssfr_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [ssfr_pkg::BYTE_W-1:0] id_r, id_nxt;
  logic                        hold_r, hold_nxt;
  logic                        take;
  logic                        id_known;
  logic [1:0]                  id_slot;

  assign in_ready  = !hold_r && !q_full;
  assign take      = in_valid && in_ready;
  assign dump_hold = hold_r;
  assign wr_addr   = pos_r[AW-1:0];
  assign wr_data   = rx_byte;

  always_comb begin
    id_known = 1'b1;
    case (id_r)
      ssfr_pkg::ID_SLOT0: id_slot = 2'd0;
      ssfr_pkg::ID_SLOT1: id_slot = 2'd1;
      ssfr_pkg::ID_SLOT2: id_slot = 2'd2;
      ssfr_pkg::ID_SLOT3: id_slot = 2'd3;
      default: begin
        id_slot  = 2'd0;
        id_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    id_nxt         = id_r;
    hold_nxt       = hold_r;
    wr_en          = 1'b0;
    ev_push        = 1'b0;
    ev_data.status = ssfr_pkg::ST_OK;
    ev_data.slot   = 2'd0;
    if (dump_done) begin
      hold_nxt = 1'b0;
    end
    if (take) begin
      if (line_error || (pos_r > TOP)) begin
        pos_nxt = TOP;
      end else begin
        wr_en = 1'b1;
        if (pos_r == TOP) begin
          pos_nxt = (rx_byte == ssfr_pkg::SYNC_BYTE) ? TOP_M1 : TOP;
        end else if (pos_r == TOP_M1) begin
          if (rx_byte == ssfr_pkg::SYNC_BYTE) begin
            pos_nxt = pos_r - 1'b1;
            sum_nxt = '0;
          end else begin
            pos_nxt = TOP;
          end
        end else if (pos_r != '0) begin
          pos_nxt = pos_r - 1'b1;
          sum_nxt = sum_r + rx_byte;
          if (pos_r == TOP_M2) begin
            id_nxt = rx_byte;
          end
        end else begin
          pos_nxt = TOP;
          ev_push = 1'b1;
          if (sum_r != rx_byte) begin
            ev_data.status = ssfr_pkg::ST_MISMATCH;
          end else if (!id_known) begin
            ev_data.status = ssfr_pkg::ST_BAD_ID;
          end else begin
            ev_data.slot = id_slot;
            hold_nxt     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= TOP;
      sum_r  <= '0;
      hold_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

// ===== rtl/ssfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfr_back
// result side: status requests or a full frame readout from the store
// ----------------------------------------------------------------------------
module ssfr_back #(
  parameter int FRAME_TOP = 40,
  parameter int AW        = $clog2(FRAME_TOP + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  ssfr_pkg::ssfr_evt_t         q_data,
  output logic                        q_pop,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [ssfr_pkg::BYTE_W-1:0] rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ssfr_pkg::ssfr_status_t      out_status,
  output logic [1:0]                  out_slot,
  output logic [ssfr_pkg::POS_W-1:0]  out_index,
  output logic [ssfr_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last,
  output logic                        dump_done
);

  localparam logic [ssfr_pkg::POS_W-1:0] TOP = ssfr_pkg::POS_W'(FRAME_TOP);

  ssfr_pkg::ssfr_bk_state_t    state_r, state_nxt;
  logic [ssfr_pkg::POS_W-1:0]  idx_r, idx_nxt;
  logic                        dump_r, dump_nxt;
  logic                        valid_r, valid_nxt;
  ssfr_pkg::ssfr_status_t      status_r, status_nxt;
  logic [1:0]                  slot_r, slot_nxt;
  logic [ssfr_pkg::POS_W-1:0]  oidx_r, oidx_nxt;
  logic [ssfr_pkg::BYTE_W-1:0] obyte_r, obyte_nxt;
  logic                        last_r, last_nxt;

  assign rd_addr    = idx_r[AW-1:0];
  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_slot   = slot_r;
  assign out_index  = oidx_r;
  assign out_byte   = obyte_r;
  assign out_last   = last_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    dump_nxt   = dump_r;
    valid_nxt  = valid_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    oidx_nxt   = oidx_r;
    obyte_nxt  = obyte_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    dump_done  = 1'b0;
    case (state_r)
      ssfr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.status == ssfr_pkg::ST_OK) begin
            dump_nxt  = 1'b1;
            idx_nxt   = TOP;
            slot_nxt  = q_data.slot;
            state_nxt = ssfr_pkg::BK_READ;
          end else begin
            dump_nxt   = 1'b0;
            valid_nxt  = 1'b1;
            status_nxt = q_data.status;
            slot_nxt   = 2'd0;
            oidx_nxt   = '0;
            obyte_nxt  = '0;
            last_nxt   = 1'b1;
            state_nxt  = ssfr_pkg::BK_HOLD;
          end
        end
      end
      ssfr_pkg::BK_READ: begin
        rd_en     = 1'b1;
        state_nxt = ssfr_pkg::BK_LOAD;
      end
      ssfr_pkg::BK_LOAD: begin
        valid_nxt  = 1'b1;
        status_nxt = ssfr_pkg::ST_OK;
        oidx_nxt   = idx_r;
        obyte_nxt  = rd_data;
        last_nxt   = (idx_r == '0);
        state_nxt  = ssfr_pkg::BK_HOLD;
      end
      ssfr_pkg::BK_HOLD: begin
        if (out_ready) begin
          valid_nxt = 1'b0;
          if (dump_r && (idx_r != '0)) begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ssfr_pkg::BK_READ;
          end else begin
            dump_done = dump_r;
            dump_nxt  = 1'b0;
            state_nxt = ssfr_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        valid_nxt = 1'b0;
        dump_nxt  = 1'b0;
        state_nxt = ssfr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssfr_pkg::BK_IDLE;
      dump_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dump_r  <= dump_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    oidx_r   <= oidx_nxt;
    obyte_r  <= obyte_nxt;
    last_r   <= last_nxt;
  end

endmodule

// ===== rtl/sync_sum_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_sum_frame_receiver
// deframer for received serial bytes with two sync bytes and an 8-bit sum
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser               | tlast
// in_     | in  | [7:0] rx_byte                  | [0] line_error      | -
// out_    | out | [5:0] byte_index [13:6] byte   | [1:0] status [3:2] slot | last
//
// a byte is taken whenever in_tvalid and in_tready are high; no request leaves for bytes inside a frame
// frame end gives one status request, or a readout of FRAME_TOP+1 bytes
// through the store read port, one byte after another: read, load, hold
// intake stops during a frame readout and while the two entry event queue is full
// synchronous active low reset puts the hunt back at position FRAME_TOP
// ----------------------------------------------------------------------------
module sync_sum_frame_receiver #(
  parameter int FRAME_TOP = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] line_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] byte_index, [13:6] frame_byte, [15:14] zero
  output logic [3:0]  out_tuser,  // [1:0] status, [3:2] slot
  output logic        out_tlast
);

  localparam int DEPTH = FRAME_TOP + 1;
  localparam int AW    = $clog2(DEPTH);

  logic                        q_push, q_pop, q_empty, q_full;
  logic [1:0]                  q_count;
  ssfr_pkg::ssfr_evt_t         q_wdata, q_rdata;
  logic                        dump_done, dump_hold;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [ssfr_pkg::BYTE_W-1:0] wr_data, rd_data;
  ssfr_pkg::ssfr_status_t      o_status;
  logic [1:0]                  o_slot;
  logic [ssfr_pkg::POS_W-1:0]  o_index;
  logic [ssfr_pkg::BYTE_W-1:0] o_byte;

  ssfr_front #(.FRAME_TOP(FRAME_TOP), .AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .rx_byte    (in_tdata),
    .line_error (in_tuser),
    .q_full     (q_full),
    .dump_done  (dump_done),
    .ev_push    (q_push),
    .ev_data    (q_wdata),
    .dump_hold  (dump_hold),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ssfr_ram #(.WIDTH(ssfr_pkg::BYTE_W), .DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssfr_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  ssfr_back #(.FRAME_TOP(FRAME_TOP), .AW(AW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (o_status),
    .out_slot   (o_slot),
    .out_index  (o_index),
    .out_byte   (o_byte),
    .out_last   (out_tlast),
    .dump_done  (dump_done)
  );

  assign out_tdata = {2'b00, o_byte, o_index};
  assign out_tuser = {o_slot, o_status};

  // no intake while a readout is pending
  a_hold_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    dump_hold |-> !in_tready)
    else $error("byte taken during frame readout");

  // status-only requests are single and final
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_status != ssfr_pkg::ST_OK)) |-> (out_tlast && (o_index == '0)))
    else $error("status request without last");

  // readout ends exactly at position zero
  a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_status == ssfr_pkg::ST_OK)) |-> (out_tlast == (o_index == '0)))
    else $error("readout last at wrong position");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3)
    else $error("event queue overflow");

endmodule

// ===== verif/tb_sync_sum_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_sum_frame_receiver
// self-checking bench for the sync/sum serial frame deframer
// ----------------------------------------------------------------------------
// bytes go in on the in_ stream with random gaps, and the out_ stream is
// stalled at random. a deframer model in the bench follows the hunt position,
// the running sum and the frame store. it queues the status or readout
// requests that each frame end must give, and every out_ request is checked
// in order against that queue. the directed tests cover each block id, the
// checksum and id failures, and the ways a hunt restarts. random frames,
// broken frames and noise follow.
// ----------------------------------------------------------------------------
module tb_sync_sum_frame_receiver;

  localparam int FRAME_TOP = 40;
  localparam int HALF_PERIOD = 6;

  typedef struct packed {
    ssfr_pkg::ssfr_status_t status;
    logic [1:0]             slot;
    logic [5:0]             idx;
    logic [7:0]             data;
    logic                   last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  // deframer model state
  logic [5:0]    rx_pos = 6'(FRAME_TOP);
  logic [7:0]    rx_sum = '0;
  logic [7:0]    rx_store [0:FRAME_TOP];
  frame_result_t pending_results [$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  stall_left = 0;
  bit  no_gaps = 1'b0;

  sync_sum_frame_receiver #(.FRAME_TOP(FRAME_TOP)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void deframe_byte(input logic [7:0] b, input logic err);
    frame_result_t r;
    logic [1:0]    slot;
    bit            known_id;
    if (err || rx_pos > FRAME_TOP) begin
      rx_pos = 6'(FRAME_TOP);
      return;
    end
    rx_store[rx_pos] = b;
    if (rx_pos == FRAME_TOP) begin
      rx_pos = (b == ssfr_pkg::SYNC_BYTE) ? 6'(FRAME_TOP - 1) : 6'(FRAME_TOP);
    end else if (rx_pos == FRAME_TOP - 1) begin
      if (b == ssfr_pkg::SYNC_BYTE) begin
        rx_pos = rx_pos - 6'd1;
        rx_sum = '0;
      end else begin
        rx_pos = 6'(FRAME_TOP);
      end
    end else if (rx_pos != 0) begin
      rx_pos = rx_pos - 6'd1;
      rx_sum = rx_sum + b;
    end else begin
      // checksum byte closes the frame
      rx_pos = 6'(FRAME_TOP);
      known_id = 1'b1;
      slot = 2'd0;
      case (rx_store[FRAME_TOP-2])
        ssfr_pkg::ID_SLOT0: slot = 2'd0;
        ssfr_pkg::ID_SLOT1: slot = 2'd1;
        ssfr_pkg::ID_SLOT2: slot = 2'd2;
        ssfr_pkg::ID_SLOT3: slot = 2'd3;
        default:  known_id = 1'b0;
      endcase
      if (rx_sum != b) begin
        r = '{ssfr_pkg::ST_MISMATCH, 2'd0, 6'd0, 8'd0, 1'b1};
        pending_results.push_back(r);
      end else if (!known_id) begin
        r = '{ssfr_pkg::ST_BAD_ID, 2'd0, 6'd0, 8'd0, 1'b1};
        pending_results.push_back(r);
      end else begin
        for (int k = FRAME_TOP; k >= 0; k--) begin
          r.status = ssfr_pkg::ST_OK;
          r.slot   = slot;
          r.idx    = 6'(k);
          r.data   = rx_store[k];
          r.last   = (k == 0);
          pending_results.push_back(r);
        end
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        stall_left = no_gaps ? 0 : $urandom_range(0, 11);
        if (pending_results.size() == 0) begin
          $error("unexpected request: status %0d slot %0d byte_index %0d",
                 out_tuser[1:0], out_tuser[3:2], out_tdata[5:0]);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tuser[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser[1:0]);
            mismatch_count++;
          end
          if (out_tuser[3:2] !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_tuser[3:2]);
            mismatch_count++;
          end
          if (out_tdata[5:0] !== want.idx) begin
            $error("byte_index: expected %0d, got %0d", want.idx, out_tdata[5:0]);
            mismatch_count++;
          end
          if (out_tdata[13:6] !== want.data) begin
            $error("frame_byte: expected 0x%02h, got 0x%02h", want.data,
                   out_tdata[13:6]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic err);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= err;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // fill < 0 gives random payload; a line error replaces the byte at break_at
  task automatic send_frame(input logic [7:0] id, input bit good_sum, input int fill,
                            input int break_at);
    logic [7:0] fr [0:FRAME_TOP];
    logic [7:0] sum;
    fr[FRAME_TOP]   = ssfr_pkg::SYNC_BYTE;
    fr[FRAME_TOP-1] = ssfr_pkg::SYNC_BYTE;
    fr[FRAME_TOP-2] = id;
    sum = id;
    for (int p = FRAME_TOP - 3; p >= 1; p--) begin
      fr[p] = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum = sum + fr[p];
    end
    fr[0] = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
    for (int p = FRAME_TOP; p >= 0; p--) begin
      if (p == break_at) begin
        send_byte(8'($urandom), 1'b1);
        break;
      end
      send_byte(fr[p], 1'b0);
    end
  endtask

  task automatic test_good_frames();
    send_frame(ssfr_pkg::ID_SLOT0, 1'b1, -1, -1);
    send_frame(ssfr_pkg::ID_SLOT1, 1'b1, 8'h00, -1);
    no_gaps = 1'b1;
    send_frame(ssfr_pkg::ID_SLOT2, 1'b1, 8'hFF, -1);
    no_gaps = 1'b0;
    send_frame(ssfr_pkg::ID_SLOT3, 1'b1, -1, -1);
  endtask

  task automatic test_checksum_mismatch();
    send_frame(ssfr_pkg::ID_SLOT0, 1'b0, -1, -1);
    // checksum failure wins over an unknown id
    send_frame(8'h00, 1'b0, -1, -1);
  endtask

  task automatic test_unknown_id();
    send_frame(8'h00, 1'b1, -1, -1);
    send_frame(8'h02, 1'b1, -1, -1);
    send_frame(8'hFF, 1'b1, 8'h00, -1);
  endtask

  task automatic test_hunt_restart();
    send_byte(8'h00, 1'b0);
    send_byte(ssfr_pkg::SYNC_BYTE, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(ssfr_pkg::SYNC_BYTE, 1'b1);
    send_frame(ssfr_pkg::ID_SLOT1, 1'b1, -1, 20);
    send_frame(ssfr_pkg::ID_SLOT2, 1'b1, -1, FRAME_TOP - 1);
    send_frame(ssfr_pkg::ID_SLOT3, 1'b1, -1, 0);
    send_frame(ssfr_pkg::ID_SLOT0, 1'b1, -1, -1);
  endtask

  task automatic test_random();
    int         start_items;
    int         pick;
    logic [7:0] id;
    start_items = items_sent;
    while (items_sent - start_items < 100) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 4))
        0: id = ssfr_pkg::ID_SLOT0;
        1: id = ssfr_pkg::ID_SLOT1;
        2: id = ssfr_pkg::ID_SLOT2;
        3: id = ssfr_pkg::ID_SLOT3;
        default: id = 8'($urandom);
      endcase
      if (pick <= 5) begin
        send_frame(id, $urandom_range(0, 6) != 0, -1, -1);
      end else if (pick == 6) begin
        send_frame(id, 1'b1, -1, $urandom_range(0, FRAME_TOP));
      end else if (pick == 7) begin
        if ($urandom_range(0, 1)) send_byte(ssfr_pkg::SYNC_BYTE, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        send_byte(8'($urandom), 1'b1);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_good_frames();
    test_checksum_mismatch();
    test_unknown_id();
    test_hunt_restart();
    test_random();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
